>>> sv/serial_frame_encoder_dual_sum_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the serial frame encoder
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_ENCODER_DUAL_SUM_DEFINES_SVH
`define SERIAL_FRAME_ENCODER_DUAL_SUM_DEFINES_SVH

// Property holds at every edge out of reset
`define SFE_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication
`define SFE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define SFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/sfe_pkg.sv
// ----------------------------------------------------------------------------
// sfe_pkg
// Types and constants shared by the serial frame encoder.
// ----------------------------------------------------------------------------
package sfe_pkg;

	localparam int BYTE_W     = 8;
	localparam int K_W        = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	// item kinds
	localparam logic ACT_BEGIN   = 1'b0;
	localparam logic ACT_PAYLOAD = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ADDR  = 1'd1;

	localparam logic [BYTE_W-1:0] START_RST = 8'hAA;
	localparam logic [BYTE_W-1:0] ADDR_RST  = 8'hFF;

	// result positions within a begin item
	localparam logic [K_W-1:0] K_START = 3'd0;
	localparam logic [K_W-1:0] K_ADDR  = 3'd1;
	localparam logic [K_W-1:0] K_TYPE  = 3'd2;
	localparam logic [K_W-1:0] K_LEN   = 3'd3;
	localparam logic [K_W-1:0] K_SUM   = 3'd4;
	localparam logic [K_W-1:0] K_SOS   = 3'd5;

	// result positions within a payload item
	localparam logic [K_W-1:0] K_DATA = 3'd0;
	localparam logic [K_W-1:0] K_PSUM = 3'd1;

	typedef struct packed {
		logic              open;
		logic [BYTE_W-1:0] rem;
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] sos;
	} sfe_state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              frame_end;
		logic              stray;
		logic              last;
	} sfe_res_t;

endpackage

>>> sv/sfe_if.sv
// ----------------------------------------------------------------------------
// sfe_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface sfe_in_if import sfe_pkg::*;;
	logic              valid;
	logic              ready;
	logic              action;
	logic [BYTE_W-1:0] frame_type;
	logic [BYTE_W-1:0] payload_length;
	logic [BYTE_W-1:0] payload_byte;

	modport source (output valid, action, frame_type, payload_length, payload_byte,
		input ready);
	modport sink (input valid, action, frame_type, payload_length, payload_byte,
		output ready);
endinterface

interface sfe_out_if import sfe_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              frame_end;
	logic              stray;
	logic              last;

	modport source (output valid, out_byte, frame_end, stray, last, input ready);
	modport sink (input valid, out_byte, frame_end, stray, last, output ready);
endinterface

>>> sv/sfe_frame.sv
// ----------------------------------------------------------------------------
// sfe_frame
// Works out result k of the held item and the frame state after it.
// ----------------------------------------------------------------------------
module sfe_frame import sfe_pkg::*; (
	input  logic              action,
	input  logic [BYTE_W-1:0] frame_type,
	input  logic [BYTE_W-1:0] payload_length,
	input  logic [BYTE_W-1:0] payload_byte,
	input  logic [K_W-1:0]    k,
	input  logic [BYTE_W-1:0] start_byte,
	input  logic [BYTE_W-1:0] address_byte,
	input  sfe_state_t        st,
	output sfe_res_t          res,
	output sfe_state_t        st_n
);

	logic              add;
	logic [BYTE_W-1:0] base_sum;
	logic [BYTE_W-1:0] base_sos;
	logic [BYTE_W-1:0] sum_n;

	always_comb begin
		res      = '0;
		st_n     = st;
		add      = 1'b0;
		base_sum = st.sum;
		base_sos = st.sos;
		if (action == ACT_BEGIN) begin
			case (k)
				K_START: begin
					// fresh sums for the new frame
					res.out_byte = start_byte;
					add          = 1'b1;
					base_sum     = '0;
					base_sos     = '0;
				end
				K_ADDR: begin
					res.out_byte = address_byte;
					add          = 1'b1;
				end
				K_TYPE: begin
					res.out_byte = frame_type;
					add          = 1'b1;
				end
				K_LEN: begin
					res.out_byte = payload_length;
					add          = 1'b1;
					st_n.open    = 1'b1;
					st_n.rem     = payload_length;
					res.last     = (payload_length != '0);
				end
				K_SUM: begin
					res.out_byte = st.sum;
				end
				K_SOS: begin
					res.out_byte  = st.sos;
					res.frame_end = 1'b1;
					res.last      = 1'b1;
					st_n.open     = 1'b0;
					st_n.rem      = '0;
				end
				default: begin
					res.last = 1'b1;
				end
			endcase
		end else if (k == K_DATA) begin
			if (!st.open) begin
				res.stray = 1'b1;
				res.last  = 1'b1;
			end else begin
				res.out_byte = payload_byte;
				add          = 1'b1;
				st_n.rem     = st.rem - 8'd1;
				// the final payload byte goes on to the two checksums
				res.last     = (st.rem != 8'd1);
				if (st.rem == 8'd1) begin
					st_n.open = 1'b0;
				end
			end
		end else if (k == K_PSUM) begin
			res.out_byte = st.sum;
		end else begin
			res.out_byte  = st.sos;
			res.frame_end = 1'b1;
			res.last      = 1'b1;
		end

		sum_n = base_sum + res.out_byte;
		if (add) begin
			st_n.sum = sum_n;
			st_n.sos = base_sos + sum_n;
		end
	end

endmodule

>>> sv/serial_frame_encoder_dual_sum.sv
// ----------------------------------------------------------------------------
// serial_frame_encoder_dual_sum
// Serial frame builder with two running 8-bit sums over the frame bytes.
// ----------------------------------------------------------------------------
// An accepted item is held in the input register; its results pass through the output register.
// Throughput: one result per cycle unless the output stalls; a begin item gives 4
// results (6 with a zero length), a payload item 1 (3 when it closes the frame).
// The next item is accepted in the cycle the held item's last result moves out.
// Reset: arst_n clears frame state, sums and valids; registers go to AA / FF.
// ----------------------------------------------------------------------------
module serial_frame_encoder_dual_sum import sfe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	sfe_in_if.sink                items,
	sfe_out_if.source             results,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic              valid_s1;
	logic              action_s1;
	logic [BYTE_W-1:0] frame_type_s1;
	logic [BYTE_W-1:0] payload_length_s1;
	logic [BYTE_W-1:0] payload_byte_s1;

	logic [K_W-1:0]    k_q;
	sfe_state_t        st_q;
	sfe_state_t        st_n;
	sfe_res_t          res;
	logic [BYTE_W-1:0] start_q;
	logic [BYTE_W-1:0] addr_q;

	logic              out_valid_q;
	sfe_res_t          out_q;

	logic              emit;
	logic              take;

	assign emit          = valid_s1 && (!out_valid_q || results.ready);
	assign items.ready   = !valid_s1 || (emit && res.last);
	assign take          = items.valid && items.ready;

	sfe_frame u_frame (
		.action         (action_s1),
		.frame_type     (frame_type_s1),
		.payload_length (payload_length_s1),
		.payload_byte   (payload_byte_s1),
		.k              (k_q),
		.start_byte     (start_q),
		.address_byte   (addr_q),
		.st             (st_q),
		.res            (res),
		.st_n           (st_n)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (emit && res.last) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			action_s1         <= items.action;
			frame_type_s1     <= items.frame_type;
			payload_length_s1 <= items.payload_length;
			payload_byte_s1   <= items.payload_byte;
		end
	end

	// result position and frame state advance once per emitted result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= '0;
			st_q <= '0;
		end else if (emit) begin
			k_q  <= res.last ? '0 : k_q + 3'd1;
			st_q <= st_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RST;
			addr_q  <= ADDR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START: start_q <= cfg_wdata;
				REG_ADDR:  addr_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.out_byte  = out_q.out_byte;
	assign results.frame_end = out_q.frame_end;
	assign results.stray     = out_q.stray;
	assign results.last      = out_q.last;

endmodule

>>> sv/sfe_check.sv
// ----------------------------------------------------------------------------
// sfe_check
// Port-level checks on the serial frame encoder, bound to its top level.
// ----------------------------------------------------------------------------
`include "serial_frame_encoder_dual_sum_defines.svh"

module sfe_check import sfe_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [BYTE_W-1:0] out_byte,
	input logic              out_frame_end,
	input logic              out_stray,
	input logic              out_last
);

	`SFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
	`SFE_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
		$stable(out_byte) && $stable(out_last), "result changed while held")
	// a held item with an empty output must produce a result next cycle
	`SFE_ASSERT_NEXT(a_no_bubble, !out_valid && !in_ready, out_valid, "bubble on output")
	`SFE_ASSERT_IMP(a_stray_form, out_valid && out_stray,
		out_last && !out_frame_end && out_byte == '0, "bad stray result")
	`SFE_ASSERT_ALWAYS(a_end_is_last, !(out_valid && out_frame_end && !out_last), "frame end not last")

endmodule

bind serial_frame_encoder_dual_sum sfe_check u_sfe_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (items.ready),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.out_byte      (results.out_byte),
	.out_frame_end (results.frame_end),
	.out_stray     (results.stray),
	.out_last      (results.last)
);
